@@ hw/rtl/fpa_pkg.sv @@
// Package: opcodes, status codes and defaults for the fixed-point ALU
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2
  } status_t;

  // Result of one operation
  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              cmp;
    status_t           st;
  } res_t;
endpackage
`default_nettype wire

@@ hw/rtl/fixed_point_alu_top.sv @@
// Top level: pipelined fixed-point ALU
//  channel | signals                                   | transfer when
//  input   | start, busy, opcode, operand_a, operand_b | start && !busy
//  result  | done, result_raw, compare_true, status    | done high
// One operation enters every cycle; busy is held low.
// done rises once an accepted operation has passed, in order: input register,
// 32+FRAC_BITS divider stages (one quotient bit each), output register.
// Synchronous reset empties the pipeline; nothing stalls.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_top #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire [3:0]          opcode,
  input  wire signed [31:0]  operand_a,
  input  wire signed [31:0]  operand_b,
  output logic               done,
  output logic signed [31:0] result_raw,
  output logic               compare_true,
  output logic [1:0]         status
);
  import fpa_pkg::*;
  localparam int NW  = 32 + FRAC_BITS;
  localparam int TW  = 1 + 1 + 1 + 4;

  logic        acc;
  logic        in_v;
  logic [3:0]  op_r;
  logic signed [31:0] a_r, b_r;
  res_t        simple_res, mul_res;
  logic        mul_v;
  logic        div_v;
  logic [NW-1:0] quo;
  logic [32:0]   rem;
  logic [TW-1:0] tag_in, tag_out;
  logic [31:0]   ma, mb;
  logic          dneg, dzero;
  logic [31:0]   mbd [1:NW];
  logic [31:0]   mb_d;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= acc;
    end
    op_r <= opcode;
    a_r  <= operand_a;
    b_r  <= operand_b;
  end

  fpa_simple #(.FRAC_BITS(FRAC_BITS)) u_simple (
    .clk(clk), .opcode(op_r), .a(a_r), .b(b_r), .res(simple_res)
  );

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .in_valid(in_v), .a(a_r), .b(b_r),
    .out_valid(mul_v), .res(mul_res)
  );

  assign ma    = a_r[31] ? 32'(-a_r) : a_r;
  assign mb    = b_r[31] ? 32'(-b_r) : b_r;
  assign dzero = b_r == '0;
  assign dneg  = (a_r[31] ^ b_r[31]) && a_r != '0;
  // tag: is div, sign, zero divisor, opcode for the bypass path
  assign tag_in = {op_r == OP_DIV, dneg, dzero, op_r};

  fpa_div #(.NW(NW), .DW(32), .TW(TW)) u_div (
    .clk(clk), .rst(rst), .in_valid(in_v),
    .num({ma, {FRAC_BITS{1'b0}}}), .den(mb), .tag_in(tag_in),
    .out_valid(div_v), .quo(quo), .rem(rem), .tag_out(tag_out)
  );

  // divisor magnitude travels alongside for the rounding compare
  always_ff @(posedge clk) begin
    mbd[1] <= mb;
    for (int k = 2; k <= NW; k++) begin
      mbd[k] <= mbd[k-1];
    end
  end
  assign mb_d = mbd[NW];

  // delay lines to align the simple and multiply results with the divider
  res_t sd [2:NW];
  res_t md [3:NW];
  always_ff @(posedge clk) begin
    sd[2] <= simple_res;
    md[3] <= mul_res;
    for (int i = 3; i <= NW; i++) begin
      sd[i] <= sd[i-1];
    end
    for (int i = 4; i <= NW; i++) begin
      md[i] <= md[i-1];
    end
  end

  logic [NW:0] qr;
  res_t        div_res, fin;
  always_comb begin
    qr = {1'b0, quo} + ((34'({rem, 1'b0}) >= 34'({1'b0, mb_d})) ? 1 : 0);
    div_res.cmp = 1'b0;
    div_res.st  = ST_OK;
    if (tag_out[4]) begin
      div_res.res = '0;
      div_res.st  = ST_DIV0;
    end else if (tag_out[5]) begin
      if (qr > (NW+1)'(33'h0_8000_0000)) begin
        div_res.res = 32'h8000_0000;
        div_res.st  = ST_OVF;
      end else begin
        div_res.res = 32'(-qr);
      end
    end else if (qr > (NW+1)'(33'h0_7FFF_FFFF)) begin
      div_res.res = 32'h7FFF_FFFF;
      div_res.st  = ST_OVF;
    end else begin
      div_res.res = qr[31:0];
    end
    if (tag_out[6]) begin
      fin = div_res;
    end else if (opcode_t'(tag_out[3:0]) == OP_MUL) begin
      fin = md[NW];
    end else begin
      fin = sd[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_v;
    end
    result_raw   <= fin.res;
    compare_true <= fin.cmp;
    status       <= fin.st;
  end

  logic unused;
  assign unused = mul_v;
endmodule
`default_nettype wire

@@ hw/rtl/fpa_div.sv @@
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module fpa_div #(
  parameter int NW = 40,
  parameter int DW = 32,
  parameter int TW = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  input  wire [NW-1:0] num,
  input  wire [DW-1:0] den,
  input  wire [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [DW:0]   rem,
  output logic [TW-1:0] tag_out
);
  // stage k holds partial remainder, shifted numerator, quotient bits so far
  logic          v   [NW+1];
  logic [DW:0]   r   [NW+1];
  logic [NW-1:0] n   [NW+1];
  logic [NW-1:0] q   [NW+1];
  logic [DW-1:0] d   [NW+1];
  logic [TW-1:0] t   [NW+1];

  always_comb begin
    v[0] = in_valid;
    r[0] = '0;
    n[0] = num;
    q[0] = '0;
    d[0] = den;
    t[0] = tag_in;
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW+1:0] shifted;
    assign shifted = {r[k], n[k][NW-1]};
    assign trial   = shifted - {2'b00, d[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      r[k+1] <= trial[DW+1] ? shifted[DW:0] : trial[DW:0];
      n[k+1] <= {n[k][NW-2:0], 1'b0};
      q[k+1] <= {q[k][NW-2:0], ~trial[DW+1]};
      d[k+1] <= d[k];
      t[k+1] <= t[k];
    end
  end

  assign out_valid = v[NW];
  assign quo       = q[NW];
  assign rem       = r[NW];
  assign tag_out   = t[NW];
endmodule
`default_nettype wire

@@ hw/rtl/fpa_mul.sv @@
// Pipelined signed multiply with rounding half away from zero
`timescale 1ns / 1ps
`default_nettype none
module fpa_mul #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  wire signed [31:0]          a,
  input  wire signed [31:0]          b,
  output logic                       out_valid,
  output fpa_pkg::res_t              res
);
  import fpa_pkg::*;
  logic        v1, v2;
  logic        neg1, neg2;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [63:0] rnd;
  logic [63:0] qmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    ma   <= a[31] ? 32'(-a) : a;
    mb   <= b[31] ? 32'(-b) : b;
    neg1 <= (a[31] ^ b[31]) && a != '0 && b != '0;
    prod <= ma * mb;
    neg2 <= neg1;
  end

  assign rnd  = prod + (64'd1 << (FRAC_BITS - 1));
  assign qmag = rnd >> FRAC_BITS;

  always_comb begin
    res.cmp = 1'b0;
    res.st  = ST_OK;
    if (neg2) begin
      if (qmag > 64'h8000_0000) begin
        res.res = 32'h8000_0000;
        res.st  = ST_OVF;
      end else begin
        res.res = 32'(-qmag);
      end
    end else if (qmag > 64'h7FFF_FFFF) begin
      res.res = 32'h7FFF_FFFF;
      res.st  = ST_OVF;
    end else begin
      res.res = qmag[31:0];
    end
  end

  assign out_valid = v2;
endmodule
`default_nettype wire

@@ hw/rtl/fpa_simple.sv @@
// Add, subtract, increment, decrement, compare, min/max and conversions, registered
`timescale 1ns / 1ps
`default_nettype none
module fpa_simple #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
  input  wire                clk,
  input  wire [3:0]          opcode,
  input  wire signed [31:0]  a,
  input  wire signed [31:0]  b,
  output fpa_pkg::res_t      res
);
  import fpa_pkg::*;
  logic signed [33:0] sum;
  logic signed [33:0] sh;
  logic signed [31:0] tr;
  logic [31:0]        bias;
  res_t               nxt;

  assign bias = (32'd1 << FRAC_BITS) - 32'd1;

  always_comb begin
    nxt.res = '0;
    nxt.cmp = 1'b0;
    nxt.st  = ST_OK;
    sum = '0;
    case (opcode_t'(opcode))
      OP_ADD: sum = 34'(a) + 34'(b);
      OP_SUB: sum = 34'(a) - 34'(b);
      OP_INC: sum = 34'(a) + 34'sd1;
      OP_DEC: sum = 34'(a) - 34'sd1;
      default: sum = '0;
    endcase
    sh = '0;
    tr = a[31] ? 32'(a + $signed(bias)) : a;
    case (opcode_t'(opcode))
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum > 34'sh0_7FFF_FFFF) begin
          nxt.res = 32'h7FFF_FFFF;
          nxt.st  = ST_OVF;
        end else if (sum < -34'sh0_8000_0000) begin
          nxt.res = 32'h8000_0000;
          nxt.st  = ST_OVF;
        end else begin
          nxt.res = sum[31:0];
        end
      end
      OP_GT: nxt.cmp = a > b;
      OP_LT: nxt.cmp = a < b;
      OP_GE: nxt.cmp = a >= b;
      OP_LE: nxt.cmp = a <= b;
      OP_EQ: nxt.cmp = a == b;
      OP_NE: nxt.cmp = a != b;
      OP_MIN: nxt.res = (a < b) ? a : b;
      OP_MAX: nxt.res = (a > b) ? a : b;
      OP_FROM_INT: begin
        // overflow when the bits shifted out differ from the sign
        sh = 34'(a >>> (31 - FRAC_BITS));
        if (!a[31] && sh != '0) begin
          nxt.res = 32'h7FFF_FFFF;
          nxt.st  = ST_OVF;
        end else if (a[31] && sh != '1) begin
          nxt.res = 32'h8000_0000;
          nxt.st  = ST_OVF;
        end else begin
          nxt.res = 32'(a <<< FRAC_BITS);
        end
      end
      OP_TO_INT: nxt.res = 32'(tr >>> FRAC_BITS);
      default: nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= nxt;
  end
endmodule
`default_nettype wire

@@ hw/rtl/fpa_checker.sv @@
// Port-level checker for the fixed-point ALU, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fpa_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire [31:0] result_raw,
  input wire        compare_true,
  input wire [1:0]  status
);
  import fpa_pkg::*;
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_OVF || status == ST_DIV0))
    else $error("bad status");
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    done && compare_true |-> result_raw == '0 && status == ST_OK)
    else $error("compare with result");
  a_div0: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_DIV0 |-> result_raw == '0 && !compare_true)
    else $error("divide by zero result");
endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .result_raw(result_raw), .compare_true(compare_true), .status(status)
);
`default_nettype wire

@@ tb/tb_fixed_point_alu_top.sv @@
// Testbench: directed table and random operations checked against a fixed-point ALU predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_fixed_point_alu_top;
  import fpa_pkg::*;

  localparam int FB      = FRAC_BITS_DEFAULT;
  localparam int LATENCY = FB + 35;
  localparam int N_RAND  = 1250;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  typedef struct {
    opcode_t           op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 typed;
    logic signed [31:0] res;
    logic               cmp;
    status_t            st;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] opcode = '0;
  logic signed [31:0] operand_a = '0, operand_b = '0;
  wire busy, done, compare_true;
  wire signed [31:0] result_raw;
  wire [1:0] status;

  res_t   pending_results[$];
  int     errors = 0;
  int     n_sent = 0, n_checked = 0;
  int     op_seen[16];
  longint cycles = 0;

  fixed_point_alu_top #(.FRAC_BITS(FB)) DUT (
    .clk, .rst, .start, .busy, .opcode, .operand_a, .operand_b,
    .done, .result_raw, .compare_true, .status
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fixed_point_alu_top: FAIL");
      $finish;
    end
  end

  function automatic longint sat32(input longint v, inout status_t st);
    if (v > longint'(MAXV)) begin st = ST_OVF; return longint'(MAXV); end
    if (v < longint'(MINV)) begin st = ST_OVF; return longint'(MINV); end
    return v;
  endfunction

  function automatic longint apply_sign(input bit neg, input longint unsigned mag,
                                        inout status_t st);
    if (neg) begin
      if (mag > 64'h80000000) begin st = ST_OVF; return longint'(MINV); end
      return -longint'(mag);
    end
    if (mag > 64'h7FFFFFFF) begin st = ST_OVF; return longint'(MAXV); end
    return longint'(mag);
  endfunction

  function automatic res_t alu_predict(input opcode_t op, input logic signed [31:0] a32,
                                       input logic signed [31:0] b32);
    longint a, b, r, p;
    longint unsigned m, q, n, d, rem;
    status_t st;
    logic cmp;
    res_t o;
    a = a32; b = b32; r = 0; st = ST_OK; cmp = 1'b0;
    case (op)
      OP_ADD: r = sat32(a + b, st);
      OP_SUB: r = sat32(a - b, st);
      OP_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        q = (m + (64'd1 << (FB - 1))) >> FB;
        r = apply_sign(p < 0, q, st);
      end
      OP_DIV: begin
        if (b == 0) st = ST_DIV0;
        else begin
          n = ((a < 0) ? -a : a) << FB;
          d = (b < 0) ? -b : b;
          q = n / d;
          rem = n % d;
          if (2 * rem >= d) q++;
          r = apply_sign(((a < 0) != (b < 0)) && n != 0, q, st);
        end
      end
      OP_GT: cmp = a > b;
      OP_LT: cmp = a < b;
      OP_GE: cmp = a >= b;
      OP_LE: cmp = a <= b;
      OP_EQ: cmp = a == b;
      OP_NE: cmp = a != b;
      OP_INC: r = sat32(a + 1, st);
      OP_DEC: r = sat32(a - 1, st);
      OP_MIN: r = (a < b) ? a : b;
      OP_MAX: r = (a > b) ? a : b;
      OP_FROM_INT: r = sat32(a * (longint'(1) << FB), st);
      default: r = a / (longint'(1) << FB);
    endcase
    o.res = r[31:0];
    o.cmp = cmp;
    o.st = st;
    return o;
  endfunction

  // result side: strobe lasts one cycle, no back-pressure
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: res=%h", result_raw);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (result_raw !== exp_r.res) begin
          $error("result_raw expected %h actual %h", exp_r.res, result_raw); errors++;
        end
        if (compare_true !== exp_r.cmp) begin
          $error("compare_true expected %b actual %b", exp_r.cmp, compare_true); errors++;
        end
        if (status !== exp_r.st) begin
          $error("status expected %0d actual %0d", exp_r.st, status); errors++;
        end
      end
    end
  end

  task automatic send_op(input opcode_t op, input logic signed [31:0] a,
                         input logic signed [31:0] b, input res_t exp_r);
    start <= 1'b1;
    opcode <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    pending_results.push_back(exp_r);
    op_seen[op]++;
    n_sent++;
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) < 7) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return MAXV - $urandom_range(0, 2);
      1: return MINV + $urandom_range(0, 2);
      2: return $signed($urandom_range(0, 1024)) - 512;
      3: return $signed($urandom) >>> $urandom_range(8, 24);
      default: return $urandom;
    endcase
  endfunction

  vec_t dir_tab[] = '{
    '{OP_ADD, MAXV, 32'sd1, 1, MAXV, 1'b0, ST_OVF},
    '{OP_ADD, MINV, -32'sd1, 1, MINV, 1'b0, ST_OVF},
    '{OP_SUB, MINV, 32'sd1, 1, MINV, 1'b0, ST_OVF},
    '{OP_SUB, MAXV, MINV, 1, MAXV, 1'b0, ST_OVF},
    '{OP_MUL, MAXV, MAXV, 1, MAXV, 1'b0, ST_OVF},
    '{OP_MUL, MINV, MAXV, 1, MINV, 1'b0, ST_OVF},
    '{OP_MUL, 32'sd384, -32'sd385, 0, '0, 1'b0, ST_OK},
    '{OP_MUL, -32'sd1, 32'sd128, 0, '0, 1'b0, ST_OK},
    '{OP_DIV, 32'sd256, 32'sd0, 1, 32'sd0, 1'b0, ST_DIV0},
    '{OP_DIV, MINV, 32'sd0, 1, 32'sd0, 1'b0, ST_DIV0},
    '{OP_DIV, MAXV, 32'sd1, 1, MAXV, 1'b0, ST_OVF},
    '{OP_DIV, MINV, -32'sd1, 1, MAXV, 1'b0, ST_OVF},
    '{OP_DIV, -32'sd1, 32'sd512, 0, '0, 1'b0, ST_OK},
    '{OP_DIV, 32'sd0, -32'sd7, 0, '0, 1'b0, ST_OK},
    '{OP_GT, MAXV, MINV, 1, 32'sd0, 1'b1, ST_OK},
    '{OP_LT, MAXV, MINV, 1, 32'sd0, 1'b0, ST_OK},
    '{OP_GE, 32'sd5, 32'sd5, 1, 32'sd0, 1'b1, ST_OK},
    '{OP_LE, MINV, MINV, 1, 32'sd0, 1'b1, ST_OK},
    '{OP_EQ, -32'sd1, -32'sd1, 1, 32'sd0, 1'b1, ST_OK},
    '{OP_NE, -32'sd1, -32'sd1, 1, 32'sd0, 1'b0, ST_OK},
    '{OP_INC, MAXV, MINV, 1, MAXV, 1'b0, ST_OVF},
    '{OP_DEC, MINV, MAXV, 1, MINV, 1'b0, ST_OVF},
    '{OP_MIN, MINV, MAXV, 1, MINV, 1'b0, ST_OK},
    '{OP_MAX, MINV, MAXV, 1, MAXV, 1'b0, ST_OK},
    '{OP_FROM_INT, MAXV, 32'sd0, 1, MAXV, 1'b0, ST_OVF},
    '{OP_TO_INT, -32'sd257, 32'sd0, 1, -32'sd1, 1'b0, ST_OK}
  };

  initial begin
    res_t exp_r;
    int   wait_cnt;
    opcode_t op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].typed) begin
        exp_r.res = dir_tab[i].res;
        exp_r.cmp = dir_tab[i].cmp;
        exp_r.st = dir_tab[i].st;
      end else begin
        exp_r = alu_predict(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b);
      end
      send_op(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, exp_r);
      if (i % 5 == 4) idle_gap();
    end

    for (int i = 0; i < N_RAND; i++) begin
      logic signed [31:0] a, b;
      op = opcode_t'($urandom_range(0, 15));
      a = rand_operand();
      b = ($urandom_range(0, 15) == 0) ? 32'sd0 :
          ($urandom_range(0, 7) == 0) ? a : rand_operand();
      // long bursts with no gaps now and then
      if (!(i % 200 < 40)) idle_gap();
      send_op(op, a, b, alu_predict(op, a, b));
    end
    start <= 1'b0;

    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 20 * LATENCY) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end

    $display("Sent %0d operations (%0d checked); all 16 opcodes used, incl. saturation,",
             n_sent, n_checked);
    $display("divide by zero and rounding ties; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("tb_fixed_point_alu_top: PASS");
    end else begin
      $display("tb_fixed_point_alu_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ fixed_point_alu_top.f @@
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_div.sv
hw/rtl/fpa_mul.sv
hw/rtl/fpa_simple.sv
hw/rtl/fixed_point_alu_top.sv
hw/rtl/fpa_checker.sv
tb/tb_fixed_point_alu_top.sv
